@@ hdl/tpcbd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpcbd_pkg
// Shared types and constants of the two-pass city-block distance transform.
// ---------------------------------------------------------------------------
package tpcbd_pkg;

  localparam int DIST_W     = 8;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [DIST_W-1:0]     DIST_SAT   = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef struct packed {
    req_t req_type;
    logic pixel;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last_flag;
    logic              status;
  } out_item_t;

endpackage
`default_nettype wire

@@ hdl/two_pass_city_block_distance.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// two_pass_city_block_distance
// City-block distance transform of a binary image held in an on-chip store.
// ---------------------------------------------------------------------------
// Set image_rows and image_cols, then send one load item per pixel in raster
// order; loads are taken one per cycle unless a read is stalled, and each
// pixel's forward value is formed from the top neighbour read from the store
// as its load is taken and the left neighbour kept in a register. After the
// last pixel, input stalls while the backward pass sweeps the store once, one
// pixel per cycle, reading own and bottom values on the store's two read ports
// and writing the result back. Read items then return distances in raster
// order, one per cycle while the output is taken, with last_flag on the final
// pixel; reads before the pass ends return status 1. The store holds
// MAX_ROWS*MAX_COLS entries and needs no clearing after reset.
// ---------------------------------------------------------------------------
module two_pass_city_block_distance #(
  parameter int MAX_ROWS = tpcbd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tpcbd_pkg::DEF_MAX_COLS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tpcbd_pkg::in_item_t               in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tpcbd_pkg::out_item_t                   out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tpcbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpcbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CN_W   = $clog2(MAX_COLS + 1);

  logic [tpcbd_pkg::CFG_DATA_W-1:0] rows_r;
  logic [tpcbd_pkg::CFG_DATA_W-1:0] cols_r;
  logic                             cfg_clear;

  logic [15:0]                  rows16;
  logic [15:0]                  cols16;
  logic [15:0]                  cap16;
  logic [31:0]                  total32;
  logic [RI_W-1:0]              rows_m1;
  logic [CI_W-1:0]              cols_m1;
  logic [CN_W-1:0]              cols;
  logic [ADDR_W-1:0]            total_m1;
  logic [tpcbd_pkg::DIST_W-1:0] cap;

  logic                         st_we;
  logic [ADDR_W-1:0]            st_waddr;
  logic [tpcbd_pkg::DIST_W-1:0] st_wdata;
  logic                         st_re_a;
  logic [ADDR_W-1:0]            st_raddr_a;
  logic [tpcbd_pkg::DIST_W-1:0] st_rdata_a;
  logic                         st_re_b;
  logic [ADDR_W-1:0]            st_raddr_b;
  logic [tpcbd_pkg::DIST_W-1:0] st_rdata_b;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= tpcbd_pkg::SIZE_RESET;
      cols_r <= tpcbd_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpcbd_pkg::CFG_IMAGE_ROWS: rows_r <= cfg_data;
        tpcbd_pkg::CFG_IMAGE_COLS: cols_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (rows_r == '0) begin
      rows16 = 16'd1;
    end else if (16'(rows_r) > 16'(MAX_ROWS)) begin
      rows16 = 16'(MAX_ROWS);
    end else begin
      rows16 = 16'(rows_r);
    end
    if (cols_r == '0) begin
      cols16 = 16'd1;
    end else if (16'(cols_r) > 16'(MAX_COLS)) begin
      cols16 = 16'(MAX_COLS);
    end else begin
      cols16 = 16'(cols_r);
    end
    cap16    = rows16 + cols16;
    total32  = 32'(rows16) * 32'(cols16);
    rows_m1  = RI_W'(rows16 - 16'd1);
    cols_m1  = CI_W'(cols16 - 16'd1);
    cols     = CN_W'(cols16);
    total_m1 = ADDR_W'(total32 - 32'd1);
    cap      = (cap16 > 16'(tpcbd_pkg::DIST_SAT)) ? tpcbd_pkg::DIST_SAT
                                                  : cap16[tpcbd_pkg::DIST_W-1:0];
  end

  tpcbd_ctrl #(
    .RI_W     (RI_W),
    .CI_W     (CI_W),
    .CN_W     (CN_W),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_clear),
    .rows_m1    (rows_m1),
    .cols_m1    (cols_m1),
    .cols       (cols),
    .total_m1   (total_m1),
    .cap        (cap),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_re_a    (st_re_a),
    .st_raddr_a (st_raddr_a),
    .st_rdata_a (st_rdata_a),
    .st_re_b    (st_re_b),
    .st_raddr_b (st_raddr_b),
    .st_rdata_b (st_rdata_b)
  );

  tpcbd_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .re_a    (st_re_a),
    .raddr_a (st_raddr_a),
    .rdata_a (st_rdata_a),
    .re_b    (st_re_b),
    .raddr_b (st_raddr_b),
    .rdata_b (st_rdata_b)
  );

endmodule
`default_nettype wire

@@ hdl/tpcbd_store.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpcbd_store
// Distance store: one write port, two read ports with enables, registered
// read data. A read of the address being written returns the old value.
// ---------------------------------------------------------------------------
module tpcbd_store #(
  parameter int DEPTH  = tpcbd_pkg::DEF_MAX_ROWS * tpcbd_pkg::DEF_MAX_COLS,
  parameter int ADDR_W = 12
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ADDR_W-1:0]             waddr,
  input  wire logic [tpcbd_pkg::DIST_W-1:0]  wdata,
  input  wire logic                          re_a,
  input  wire logic [ADDR_W-1:0]             raddr_a,
  output logic      [tpcbd_pkg::DIST_W-1:0]  rdata_a,
  input  wire logic                          re_b,
  input  wire logic [ADDR_W-1:0]             raddr_b,
  output logic      [tpcbd_pkg::DIST_W-1:0]  rdata_b
);

  logic [tpcbd_pkg::DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ hdl/tpcbd_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpcbd_ctrl
// Sequencer of the transform: forward pass on loads, backward pass sweep,
// readout, and the output register. Drives the store's ports.
// ---------------------------------------------------------------------------
module tpcbd_ctrl #(
  parameter int RI_W     = 6,
  parameter int CI_W     = 6,
  parameter int CN_W     = 7,
  parameter int ADDR_W   = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // sizes, settled from the configuration registers
  input  wire logic                          cfg_clear,
  input  wire logic [RI_W-1:0]               rows_m1,
  input  wire logic [CI_W-1:0]               cols_m1,
  input  wire logic [CN_W-1:0]               cols,
  input  wire logic [ADDR_W-1:0]             total_m1,
  input  wire logic [tpcbd_pkg::DIST_W-1:0]  cap,
  // item channels
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tpcbd_pkg::in_item_t           in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tpcbd_pkg::out_item_t               out_item,
  // store ports
  output logic                               st_we,
  output logic      [ADDR_W-1:0]             st_waddr,
  output logic      [tpcbd_pkg::DIST_W-1:0]  st_wdata,
  output logic                               st_re_a,
  output logic      [ADDR_W-1:0]             st_raddr_a,
  input  wire logic [tpcbd_pkg::DIST_W-1:0]  st_rdata_a,
  output logic                               st_re_b,
  output logic      [ADDR_W-1:0]             st_raddr_b,
  input  wire logic [tpcbd_pkg::DIST_W-1:0]  st_rdata_b
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WAIT,
    ST_BWD,
    ST_BLAST
  } state_t;

  typedef logic [tpcbd_pkg::DIST_W-1:0] dist_t;

  // min of two neighbours plus one, saturated at the cap
  function automatic dist_t relax(dist_t a, dist_t b, dist_t lim);
    dist_t                     m;
    logic [tpcbd_pkg::DIST_W:0] s;
    m = (a < b) ? a : b;
    s = {1'b0, m} + 1'b1;
    if (s > {1'b0, lim}) begin
      return lim;
    end
    return s[tpcbd_pkg::DIST_W-1:0];
  endfunction

  state_t            state_r;
  logic [ADDR_W-1:0] load_pos_r;
  logic [RI_W-1:0]   load_row_r;
  logic [CI_W-1:0]   load_col_r;
  logic [ADDR_W-1:0] read_pos_r;
  logic              done_r;

  // forward write stage
  logic              ws_valid_r;
  logic              ws_pix_r;
  logic              ws_row0_r;
  logic              ws_col0_r;
  logic [ADDR_W-1:0] ws_addr_r;

  // backward sweep position and its write stage
  logic [ADDR_W-1:0] bwd_pos_r;
  logic [RI_W-1:0]   bwd_row_r;
  logic [CI_W-1:0]   bwd_col_r;
  logic              bs_valid_r;
  logic              bs_lastrow_r;
  logic              bs_lastcol_r;
  logic [ADDR_W-1:0] bs_addr_r;

  // last value written, stands in for left, right and the one-column neighbour
  dist_t             prev_r;

  // readout stage waiting for the output register
  logic              rp_valid_r;
  logic              rp_nr_r;
  logic              rp_last_r;

  logic                 out_valid_r;
  tpcbd_pkg::out_item_t out_item_r;

  logic      acc;
  logic      acc_load;
  logic      acc_read;
  logic      rp_move;
  logic      cols_one;
  logic      load_last;
  logic      read_last;
  dist_t     top_v;
  dist_t     left_v;
  dist_t     fwd_v;
  dist_t     bottom_v;
  dist_t     right_v;
  dist_t     relaxed_v;
  dist_t     bwd_v;

  assign cols_one  = (cols_m1 == '0);
  assign rp_move   = rp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_RUN) || (rp_valid_r && !rp_move);
  assign acc       = in_valid && !in_stall;
  assign acc_load  = acc && (in_item.req_type == tpcbd_pkg::REQ_LOAD);
  assign acc_read  = acc && (in_item.req_type == tpcbd_pkg::REQ_READ);
  assign load_last = (load_pos_r == total_m1);
  assign read_last = (read_pos_r == total_m1);

  always_comb begin
    top_v     = ws_row0_r ? cap : (cols_one ? prev_r : st_rdata_a);
    left_v    = ws_col0_r ? cap : prev_r;
    fwd_v     = ws_pix_r ? relax(top_v, left_v, cap) : '0;
    bottom_v  = bs_lastrow_r ? cap : (cols_one ? prev_r : st_rdata_b);
    right_v   = bs_lastcol_r ? cap : prev_r;
    relaxed_v = relax(bottom_v, right_v, cap);
    bwd_v     = (st_rdata_a < relaxed_v) ? st_rdata_a : relaxed_v;
  end

  always_comb begin
    st_we    = ws_valid_r || bs_valid_r;
    st_waddr = bs_valid_r ? bs_addr_r : ws_addr_r;
    st_wdata = bs_valid_r ? bwd_v : fwd_v;
    if (state_r == ST_BWD) begin
      st_re_a    = 1'b1;
      st_raddr_a = bwd_pos_r;
      st_re_b    = 1'b1;
      st_raddr_b = ADDR_W'(32'(bwd_pos_r) + 32'(cols));
    end else begin
      st_re_a    = acc_load;
      st_raddr_a = ADDR_W'(32'(load_pos_r) - 32'(cols));
      st_re_b    = acc_read && done_r;
      st_raddr_b = read_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      load_pos_r  <= '0;
      load_row_r  <= '0;
      load_col_r  <= '0;
      read_pos_r  <= '0;
      done_r      <= 1'b0;
      ws_valid_r  <= 1'b0;
      bs_valid_r  <= 1'b0;
      rp_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ws_valid_r <= acc_load;
      bs_valid_r <= (state_r == ST_BWD);

      if (acc_load) begin
        ws_pix_r  <= in_item.pixel;
        ws_row0_r <= (load_row_r == '0);
        ws_col0_r <= (load_col_r == '0);
        ws_addr_r <= load_pos_r;
        done_r    <= 1'b0;
        if (load_last) begin
          load_pos_r <= '0;
          load_row_r <= '0;
          load_col_r <= '0;
          bwd_pos_r  <= total_m1;
          bwd_row_r  <= rows_m1;
          bwd_col_r  <= cols_m1;
          state_r    <= ST_WAIT;
        end else begin
          load_pos_r <= load_pos_r + ADDR_W'(1);
          if (load_col_r == cols_m1) begin
            load_col_r <= '0;
            load_row_r <= load_row_r + RI_W'(1);
          end else begin
            load_col_r <= load_col_r + CI_W'(1);
          end
        end
      end

      if (ws_valid_r) begin
        prev_r <= fwd_v;
      end
      if (bs_valid_r) begin
        prev_r <= bwd_v;
      end

      unique case (state_r)
        ST_RUN: begin
        end
        ST_WAIT: begin
          // last pixel is being written, sweep starts next cycle
          state_r <= ST_BWD;
        end
        ST_BWD: begin
          bs_addr_r    <= bwd_pos_r;
          bs_lastrow_r <= (bwd_row_r == rows_m1);
          bs_lastcol_r <= (bwd_col_r == cols_m1);
          if (bwd_pos_r == '0) begin
            state_r <= ST_BLAST;
          end else begin
            bwd_pos_r <= bwd_pos_r - ADDR_W'(1);
            if (bwd_col_r == '0) begin
              bwd_col_r <= cols_m1;
              bwd_row_r <= bwd_row_r - RI_W'(1);
            end else begin
              bwd_col_r <= bwd_col_r - CI_W'(1);
            end
          end
        end
        ST_BLAST: begin
          done_r     <= 1'b1;
          read_pos_r <= '0;
          state_r    <= ST_RUN;
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase

      if (acc_read) begin
        rp_valid_r <= 1'b1;
        rp_nr_r    <= !done_r;
        rp_last_r  <= done_r && read_last;
        if (done_r) begin
          read_pos_r <= read_last ? '0 : read_pos_r + ADDR_W'(1);
        end
      end else if (rp_move) begin
        rp_valid_r <= 1'b0;
      end

      if (rp_move) begin
        out_valid_r          <= 1'b1;
        out_item_r.distance  <= rp_nr_r ? '0 : st_rdata_b;
        out_item_r.last_flag <= rp_last_r;
        out_item_r.status    <= rp_nr_r ? tpcbd_pkg::STATUS_NOT_READY
                                        : tpcbd_pkg::STATUS_OK;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // a size write starts a fresh image
      if (cfg_clear) begin
        load_pos_r <= '0;
        load_row_r <= '0;
        load_col_r <= '0;
        read_pos_r <= '0;
        done_r     <= 1'b0;
        state_r    <= ST_RUN;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ verif/two_pass_city_block_distance_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// two_pass_city_block_distance testbench
// Loads binary images pixel by pixel, reads the distance maps back and checks
// every result against a shadow two-pass city-block transform or a given
// value. A short directed table covers reset, the smallest images, clamped
// sizes, reads before the transform ends, read wrap-around and aborted loads;
// random phases then sweep image sizes, zero densities and handshake idling.
// ---------------------------------------------------------------------------
module testbench;
  import tpcbd_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_AFTER  = 950;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int REPORT_MAX   = 10;
  localparam int STORE_DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLS;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  two_pass_city_block_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the block's state
  logic [CFG_DATA_W-1:0] rows_reg = SIZE_RESET;
  logic [CFG_DATA_W-1:0] cols_reg = SIZE_RESET;
  logic [DIST_W-1:0]     dist_shadow [STORE_DEPTH];
  int                    load_pos = 0;
  int                    read_pos = 0;
  bit                    img_done = 1'b0;

  out_item_t pending_distances [$];

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  int sent_items     = 0;
  int rand_items     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  bit idle_on        = 1'b1;
  bit quiet          = 1'b0;

  bit        took_result = 1'b0;
  out_item_t got_result;

  function automatic int eff_size(logic [CFG_DATA_W-1:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic void sweep_bottom_right(int rows, int cols, int cap);
    int idx, below, right, v;
    for (int i = rows - 1; i >= 0; i--) begin
      for (int j = cols - 1; j >= 0; j--) begin
        idx = i * cols + j;
        if (dist_shadow[idx] != '0) begin
          below = (i + 1 < rows) ? int'(dist_shadow[idx + cols]) : cap;
          right = (j + 1 < cols) ? int'(dist_shadow[idx + 1]) : cap;
          v = ((below < right) ? below : right) + 1;
          if (v > cap) v = cap;
          if (v < int'(dist_shadow[idx])) dist_shadow[idx] = DIST_W'(v);
        end
      end
    end
  endfunction

  function automatic void apply_transform_item(input in_item_t it, output bit emits,
                                               output out_item_t res);
    int rows, cols, total, cap, pos, top, left, v;
    rows  = eff_size(rows_reg, DEF_MAX_ROWS);
    cols  = eff_size(cols_reg, DEF_MAX_COLS);
    total = rows * cols;
    cap   = rows + cols;
    if (cap > 255) cap = 255;
    emits = 1'b0;
    res   = '0;
    if (it.req_type == REQ_LOAD) begin
      // a load after a finished image starts a new one
      if (img_done) begin
        img_done = 1'b0;
        load_pos = 0;
        read_pos = 0;
      end
      if (load_pos >= total) load_pos = 0;
      pos = load_pos;
      if (it.pixel == 1'b0) begin
        dist_shadow[pos] = '0;
      end else begin
        top  = (pos / cols > 0) ? int'(dist_shadow[pos - cols]) : cap;
        left = (pos % cols > 0) ? int'(dist_shadow[pos - 1]) : cap;
        v = ((top < left) ? top : left) + 1;
        if (v > cap) v = cap;
        dist_shadow[pos] = DIST_W'(v);
      end
      if (pos + 1 >= total) begin
        sweep_bottom_right(rows, cols, cap);
        img_done = 1'b1;
        load_pos = 0;
        read_pos = 0;
      end else begin
        load_pos = pos + 1;
      end
    end else begin
      emits = 1'b1;
      if (!img_done) begin
        res.status = STATUS_NOT_READY;
      end else begin
        if (read_pos >= total) read_pos = 0;
        res.distance  = dist_shadow[read_pos];
        res.last_flag = (read_pos + 1 >= total);
        res.status    = STATUS_OK;
        read_pos      = (read_pos + 1 >= total) ? 0 : read_pos + 1;
      end
    end
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_req(req_t r, logic pix, bit typed = 1'b0,
                                  logic [DIST_W-1:0] d = '0, logic lf = 1'b0,
                                  logic st = STATUS_OK);
    dir_row_t row;
    row                = '{default: '0};
    row.item.req_type  = r;
    row.item.pixel     = pix;
    row.typed          = typed;
    row.want.distance  = d;
    row.want.last_flag = lf;
    row.want.status    = st;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 127;
      2: return DEF_MAX_ROWS;
      3: return $urandom_range(9, 20);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic void report_failure(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s: expected dist %0d last %0b status %0b, got dist %0d last %0b status %0b",
               what, want.distance, want.last_flag, want.status,
               got.distance, got.last_flag, got.status);
  endfunction

  task automatic drop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    drop_input();
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int settle;
    drain_results();
    // a trailing load may still be running the backward sweep
    settle = eff_size(rows_reg, DEF_MAX_ROWS) * eff_size(cols_reg, DEF_MAX_COLS) + 16;
    repeat (settle) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IMAGE_ROWS) rows_reg = data;
    else cols_reg = data;
    load_pos = 0;
    read_pos = 0;
    img_done = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    bit        emits;
    out_item_t res;
    gap = 0;
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    apply_transform_item(it, emits, res);
    if (emits) pending_distances.insert(pending_distances.size(), typed ? want : res);
    sent_items++;
  endtask

  task automatic send_req(req_t r, logic pix);
    in_item_t it;
    it.req_type = r;
    it.pixel    = pix;
    send_item(it, 1'b0, '0);
  endtask

  // receiver stall bursts
  always @(negedge clk) begin
    if (!idle_on || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // capture at the rising edge, compare at the falling edge
  always @(posedge clk) begin
    took_result = rst_n && out_valid && !out_stall;
    got_result  = out_item;
  end

  always @(negedge clk) begin : check_result
    out_item_t want;
    if (took_result) begin
      if (pending_distances.size() == 0) begin
        report_failure("result with nothing pending", '0, got_result);
      end else begin
        want = pending_distances.pop_front();
        if (got_result.distance !== want.distance || got_result.last_flag !== want.last_flag
            || got_result.status !== want.status)
          report_failure("result mismatch", want, got_result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int rv, cv, total, n_img, thr, stop, reads, phase_start;

    // directed table
    add_req(REQ_READ, 1'b0, 1'b1, 8'd0, 1'b0, STATUS_NOT_READY);
    add_cfg(CFG_IMAGE_ROWS, 7'd1);
    add_cfg(CFG_IMAGE_COLS, 7'd1);
    add_req(REQ_LOAD, 1'b1);
    add_req(REQ_READ, 1'b0, 1'b1, 8'd2, 1'b1, STATUS_OK);
    add_req(REQ_READ, 1'b1, 1'b1, 8'd2, 1'b1, STATUS_OK);
    add_req(REQ_LOAD, 1'b0);
    add_req(REQ_READ, 1'b0, 1'b1, 8'd0, 1'b1, STATUS_OK);
    // zero rows clamps to one
    add_cfg(CFG_IMAGE_ROWS, 7'd0);
    add_cfg(CFG_IMAGE_COLS, 7'd3);
    add_req(REQ_LOAD, 1'b1);
    add_req(REQ_READ, 1'b0, 1'b1, 8'd0, 1'b0, STATUS_NOT_READY);
    add_req(REQ_LOAD, 1'b0);
    add_req(REQ_LOAD, 1'b1);
    repeat (3) add_req(REQ_READ, 1'b0);
    add_cfg(CFG_IMAGE_ROWS, 7'd2);
    add_cfg(CFG_IMAGE_COLS, 7'd2);
    repeat (3) add_req(REQ_LOAD, 1'b1);
    add_req(REQ_READ, 1'b1, 1'b1, 8'd0, 1'b0, STATUS_NOT_READY);
    add_req(REQ_LOAD, 1'b0);
    repeat (4) add_req(REQ_READ, 1'b0);
    // partial image aborted by a size write
    add_req(REQ_LOAD, 1'b1);
    add_cfg(CFG_IMAGE_COLS, 7'd2);
    add_req(REQ_READ, 1'b0, 1'b1, 8'd0, 1'b0, STATUS_NOT_READY);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_size(dir_rows[k].idx, dir_rows[k].data);
      else send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    while (rand_items < RANDOM_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      phase_start = sent_items;
      rv = pick_size();
      cv = pick_size();
      if (eff_size(CFG_DATA_W'(rv), DEF_MAX_ROWS) > 8 &&
          eff_size(CFG_DATA_W'(cv), DEF_MAX_COLS) > 3)
        cv = $urandom_range(1, 3);
      if ($urandom_range(0, 3) != 0) begin
        write_size(CFG_IMAGE_ROWS, CFG_DATA_W'(rv));
        write_size(CFG_IMAGE_COLS, CFG_DATA_W'(cv));
      end else begin
        write_size(CFG_IMAGE_COLS, CFG_DATA_W'($urandom_range(1, 8)));
      end
      total = eff_size(rows_reg, DEF_MAX_ROWS) * eff_size(cols_reg, DEF_MAX_COLS);
      n_img = $urandom_range(1, 3);
      repeat (n_img) begin
        case ($urandom_range(0, 3))
          0: thr = 0;
          1: thr = 1;
          2: thr = 4;
          default: thr = 7;
        endcase
        // now and then an image is cut short
        stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
        for (int p = 0;
             p < stop && rand_items + sent_items - phase_start < RANDOM_ITEMS; p++) begin
          if ($urandom_range(0, 23) == 0) send_req(REQ_READ, 1'($urandom_range(0, 1)));
          send_req(REQ_LOAD, ($urandom_range(0, 7) < thr) ? 1'b0 : 1'b1);
        end
        case ($urandom_range(0, 3))
          2: reads = total + $urandom_range(1, total);
          3: reads = $urandom_range(1, total);
          default: reads = total;
        endcase
        if (total > 256) reads = 128;
        for (int k = 0;
             k < reads && rand_items + sent_items - phase_start < RANDOM_ITEMS; k++)
          send_req(REQ_READ, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) drain_results();
      end
      rand_items += sent_items - phase_start;
      quiet = rand_items >= QUIET_AFTER;
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_distances.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
